// ----- hw/rtl/osdrl_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and codes for the OSD run-length character buffer.
// No dependencies.
package osdrl_pkg;

    // default screen geometry
    localparam int COLS_DEF = 64;
    localparam int ROWS_DEF = 32;

    // field widths
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;
    localparam int CODE_W = 9;
    localparam int RUN_W  = 7;

    // request opcodes
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // payload byte codes
    localparam logic [BYTE_W-1:0] BYTE_ESC  = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_BANK = 8'hff;

endpackage

// ----- hw/rtl/osd_run_length_char_buffer_unit.sv -----
`timescale 1ns / 1ps
// Top level of the OSD run-length character buffer.
// Depends on osdrl_pkg and osdrl_ram.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one request: a payload
//   byte (op 0), a cell read (op 1) or a store clear (op 2); op 3 is taken
//   and dropped. Output channel (o_out_valid / i_out_ready) carries the
//   9-bit code of each read cell, bit 8 being the bank.
// Per request, one request at a time:
//   - literal, prefix or count byte: the cell write, if any, happens in
//     the accept cycle
//   - run character byte: after the accept, one cell write per cycle for
//     each cell of the run, from the single RAM write port
//   - cell read: the result passes the RAM read register, then sits in an
//     output register, so later requests are taken while it waits
//   - clear: one cell zeroed per cycle over all ROWS*COLS cells
// Reset: decoder returns to row 0, column 0, bank 0; then a clearing pass
//   over all ROWS*COLS cells zeroes the store, o_in_ready low throughout.
// Stall: if a second read finishes while the previous result is still
//   unclaimed, the block holds the RAM data and waits for i_out_ready.
// Reads outside ROWS x COLS return zero.
module osd_run_length_char_buffer_unit #(
    parameter int COLS = osdrl_pkg::COLS_DEF,
    parameter int ROWS = osdrl_pkg::ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [osdrl_pkg::OP_W-1:0]       i_op,
    input  logic [osdrl_pkg::BYTE_W-1:0]     i_payload_byte,
    input  logic                             i_last_of_payload,
    input  logic [osdrl_pkg::ROW_W-1:0]      i_read_row,
    input  logic [osdrl_pkg::COL_W-1:0]      i_read_col,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [osdrl_pkg::CODE_W-1:0]     o_char_code
);

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CODE_W = osdrl_pkg::CODE_W;
    localparam int RUN_W  = osdrl_pkg::RUN_W;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
    localparam logic [6:0]        ROWS_V    = 7'(ROWS);
    localparam logic [8:0]        COLS_V    = 9'(COLS);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_COUNT,
        PH_RUNCHAR,
        PH_LITERAL
    } t_phase;

    // control
    t_state                  r_state,    n_state;
    t_phase                  r_phase,    n_phase;
    logic                    r_bank,     n_bank;
    logic                    r_ended,    n_ended;
    logic [ADDR_W-1:0]       r_cur_addr, n_cur_addr;   // linear cursor
    logic [RUN_W-1:0]        r_run,      n_run;
    logic                    r_last_pend, n_last_pend;
    logic [ADDR_W-1:0]       r_clr_addr, n_clr_addr;
    logic                    r_read_zero, n_read_zero;
    logic                    r_out_valid, n_out_valid;
    // payload
    logic [7:0]              r_run_char, n_run_char;
    logic [CODE_W-1:0]       r_char_code, n_char_code;

    // RAM port
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [CODE_W-1:0]       ram_wdata;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [CODE_W-1:0]       ram_rdata;

    logic                    in_acc;
    logic                    rd_in_range;
    logic                    out_take;
    logic [ADDR_W-1:0]       cur_addr_inc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char_code;

    assign rd_in_range = ({2'b00, i_read_row} < ROWS_V) && ({3'b000, i_read_col} < COLS_V);
    assign ram_raddr   = ADDR_W'(ADDR_W'(i_read_row) * COLS_A) + ADDR_W'(i_read_col);
    assign ram_re      = in_acc && (i_op == osdrl_pkg::OP_READ) && rd_in_range;

    // cursor walks the store linearly; wrap at the last cell
    assign cur_addr_inc = (r_cur_addr == ADDR_LAST) ? '0 : r_cur_addr + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_bank      = r_bank;
        n_ended     = r_ended;
        n_cur_addr  = r_cur_addr;
        n_run       = r_run;
        n_last_pend = r_last_pend;
        n_clr_addr  = r_clr_addr;
        n_read_zero = r_read_zero;
        n_out_valid = r_out_valid && !out_take;
        n_run_char  = r_run_char;
        n_char_code = r_char_code;
        ram_we      = 1'b0;
        ram_waddr   = r_cur_addr;
        ram_wdata   = {r_bank, r_run_char};

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_LAST) begin
                    n_clr_addr = '0;
                    n_state    = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (in_acc) begin
                    case (i_op)
                        osdrl_pkg::OP_BYTE: begin
                            if (!r_ended) begin
                                case (r_phase)
                                    PH_PLAIN: begin
                                        if (i_payload_byte == osdrl_pkg::BYTE_ESC) begin
                                            n_phase = PH_COUNT;
                                        end else if (i_payload_byte == osdrl_pkg::BYTE_BANK) begin
                                            n_bank  = !r_bank;
                                            n_phase = PH_LITERAL;
                                        end else begin
                                            ram_we     = 1'b1;
                                            ram_wdata  = {r_bank, i_payload_byte};
                                            n_cur_addr = cur_addr_inc;
                                        end
                                    end
                                    PH_COUNT: begin
                                        n_run = i_payload_byte[RUN_W-1:0];
                                        if (i_payload_byte[RUN_W-1:0] == '0) begin
                                            n_ended = 1'b1;
                                            n_phase = PH_PLAIN;
                                        end else begin
                                            n_bank  = r_bank ^ i_payload_byte[7];
                                            n_phase = PH_RUNCHAR;
                                        end
                                    end
                                    PH_RUNCHAR: begin
                                        // run length is nonzero here
                                        n_run_char  = i_payload_byte;
                                        n_last_pend = i_last_of_payload;
                                        n_phase     = PH_PLAIN;
                                        n_state     = ST_RUN;
                                    end
                                    default: begin
                                        ram_we     = 1'b1;
                                        ram_wdata  = {r_bank, i_payload_byte};
                                        n_cur_addr = cur_addr_inc;
                                        n_phase    = PH_PLAIN;
                                    end
                                endcase
                            end
                            // last byte restarts now, unless a run still has to go out
                            if (i_last_of_payload && (r_ended || r_phase != PH_RUNCHAR)) begin
                                n_phase    = PH_PLAIN;
                                n_bank     = 1'b0;
                                n_cur_addr = '0;
                                n_run      = '0;
                                n_ended    = 1'b0;
                            end
                        end
                        osdrl_pkg::OP_READ: begin
                            n_read_zero = !rd_in_range;
                            n_state     = ST_READ;
                        end
                        osdrl_pkg::OP_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_RUN: begin
                ram_we     = 1'b1;
                n_cur_addr = cur_addr_inc;
                n_run      = r_run - 1'b1;
                if (r_run == RUN_W'(1)) begin
                    n_state = ST_IDLE;
                    if (r_last_pend) begin
                        n_phase    = PH_PLAIN;
                        n_bank     = 1'b0;
                        n_cur_addr = '0;
                        n_run      = '0;
                        n_ended    = 1'b0;
                    end
                end
            end

            ST_READ: begin
                // RAM data holds until the next read, so waiting is safe
                if (!r_out_valid || i_out_ready) begin
                    n_char_code = r_read_zero ? '0 : ram_rdata;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_phase     <= PH_PLAIN;
            r_bank      <= 1'b0;
            r_ended     <= 1'b0;
            r_cur_addr  <= '0;
            r_run       <= '0;
            r_last_pend <= 1'b0;
            r_clr_addr  <= '0;
            r_read_zero <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_bank      <= n_bank;
            r_ended     <= n_ended;
            r_cur_addr  <= n_cur_addr;
            r_run       <= n_run;
            r_last_pend <= n_last_pend;
            r_clr_addr  <= n_clr_addr;
            r_read_zero <= n_read_zero;
            r_out_valid <= n_out_valid;
        end
        r_run_char  <= n_run_char;
        r_char_code <= n_char_code;
    end

    osdrl_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ----- hw/rtl/osdrl_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module osdrl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/osdrl_chk.sv -----
`timescale 1ns / 1ps
// Port-level checks for the OSD run-length character buffer, bound to the top.
// Depends on osdrl_pkg.
module osdrl_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [osdrl_pkg::OP_W-1:0]   i_op,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [osdrl_pkg::CODE_W-1:0] o_char_code
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_char_code))
        else $error("result dropped or changed while stalled");

    // clearing pass follows reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request taken during reset clearing pass");

    // clear request blocks intake while sweeping
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_op == osdrl_pkg::OP_CLEAR |=> !o_in_ready)
        else $error("request taken during clear sweep");

    // read into empty output register shows its result via ST_READ and the output register
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_op == osdrl_pkg::OP_READ && !o_out_valid |=> ##1 o_out_valid)
        else $error("read result late");

endmodule

bind osd_run_length_char_buffer_unit osdrl_chk u_osdrl_chk (.*);

// ----- dv/osd_run_length_char_buffer_checker.sv -----
`timescale 1ns / 1ps
// Checker for the OSD run-length character buffer: watches both channels,
// decodes accepted requests into its own screen store, checks read codes.
// Depends on osdrl_pkg.
module osd_run_length_char_buffer_checker #(
    parameter int COLS = osdrl_pkg::COLS_DEF,
    parameter int ROWS = osdrl_pkg::ROWS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [osdrl_pkg::OP_W-1:0]   i_op,
    input  logic [osdrl_pkg::BYTE_W-1:0] i_payload_byte,
    input  logic                         i_last_of_payload,
    input  logic [osdrl_pkg::ROW_W-1:0]  i_read_row,
    input  logic [osdrl_pkg::COL_W-1:0]  i_read_col,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [osdrl_pkg::CODE_W-1:0] i_char_code,
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam int CODE_W = osdrl_pkg::CODE_W;
    localparam int RUN_W  = osdrl_pkg::RUN_W;
    localparam int BYTE_W = osdrl_pkg::BYTE_W;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_COUNT,
        PH_RUNCHAR,
        PH_LITERAL
    } t_phase;

    logic [CODE_W-1:0] screen [ROWS*COLS];
    logic [CODE_W-1:0] code_q [$];

    t_phase         phase;
    logic           bank;
    int unsigned    cur_row;
    int unsigned    cur_col;
    logic [RUN_W-1:0] run_len;
    logic           stopped;
    int             mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic wipe_screen();
        for (int i = 0; i < ROWS*COLS; i++) begin
            screen[i] = '0;
        end
    endtask

    task automatic restart_decode();
        phase   = PH_PLAIN;
        bank    = 1'b0;
        cur_row = 0;
        cur_col = 0;
        run_len = '0;
        stopped = 1'b0;
    endtask

    // write at the cursor, then step right with column and row wrap
    task automatic write_cell(input logic [BYTE_W-1:0] ch);
        if (cur_row < ROWS && cur_col < COLS) begin
            screen[cur_row*COLS + cur_col] = {bank, ch};
        end
        cur_col++;
        if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) begin
                cur_row = 0;
            end
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        if (!stopped) begin
            case (phase)
                PH_PLAIN: begin
                    if (b == osdrl_pkg::BYTE_ESC) begin
                        phase = PH_COUNT;
                    end else if (b == osdrl_pkg::BYTE_BANK) begin
                        bank  = ~bank;
                        phase = PH_LITERAL;
                    end else begin
                        write_cell(b);
                    end
                end
                PH_COUNT: begin
                    run_len = b[RUN_W-1:0];
                    if (run_len == 0) begin
                        // zero count ends the payload
                        stopped = 1'b1;
                        phase   = PH_PLAIN;
                    end else begin
                        if (b[BYTE_W-1]) begin
                            bank = ~bank;
                        end
                        phase = PH_RUNCHAR;
                    end
                end
                PH_RUNCHAR: begin
                    while (run_len > 0) begin
                        write_cell(b);
                        run_len--;
                    end
                    phase = PH_PLAIN;
                end
                default: begin
                    write_cell(b);
                    phase = PH_PLAIN;
                end
            endcase
        end
    endtask

    function automatic logic [CODE_W-1:0] cell_code(input int unsigned row,
                                                    input int unsigned col);
        logic [CODE_W-1:0] code;
        code = '0;
        if (row < ROWS && col < COLS) begin
            code = screen[row*COLS + col];
        end
        return code;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_screen();
            restart_decode();
            code_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (code_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected code %03h", i_char_code));
                end else if (i_char_code !== code_q[0]) begin
                    report_mismatch($sformatf("char_code got %03h want %03h",
                                              i_char_code, code_q[0]));
                    void'(code_q.pop_front());
                end else begin
                    void'(code_q.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_op)
                    osdrl_pkg::OP_BYTE: begin
                        decode_byte(i_payload_byte);
                        if (i_last_of_payload) begin
                            restart_decode();
                        end
                    end
                    osdrl_pkg::OP_READ:  code_q.push_back(cell_code(i_read_row, i_read_col));
                    osdrl_pkg::OP_CLEAR: wipe_screen();
                    default: ;
                endcase
            end
            o_pending <= code_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Top of the OSD run-length character buffer testbench: clock, reset,
// request stimulus and verdict. Depends on osdrl_pkg, the block and its checker.
module tb;

    localparam int OP_W       = osdrl_pkg::OP_W;
    localparam int BYTE_W     = osdrl_pkg::BYTE_W;
    localparam int ROW_W      = osdrl_pkg::ROW_W;
    localparam int COL_W      = osdrl_pkg::COL_W;
    localparam int CODE_W     = osdrl_pkg::CODE_W;
    localparam int RUN_W      = osdrl_pkg::RUN_W;
    localparam int COLS       = osdrl_pkg::COLS_DEF;
    localparam int ROWS       = osdrl_pkg::ROWS_DEF;
    localparam int N_RANDOM   = 1600;
    // cap set well above the length of a slow correct run
    localparam int CYCLE_CAP  = 2_000_000;
    // longest request the block can still be busy with (a clear), plus slack
    localparam int DRAIN_WAIT = ROWS*COLS + 200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    op = osdrl_pkg::OP_NONE;
    logic [BYTE_W-1:0]  payload_byte = '0;
    logic               last_flag = 1'b0;
    logic [ROW_W-1:0]   read_row = '0;
    logic [COL_W-1:0]   read_col = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CODE_W-1:0]  char_code;

    int fail_count;
    int pending_reads;
    int cycle_count = 0;
    int req_count = 0;          // requests that do something (op 3 excluded)
    int send_idle_pct = 37;     // chance per slot that the sender holds back
    int recv_idle_pct = 72;     // chance per cycle that the receiver stalls

    logic [BYTE_W-1:0] stream [$];   // bytes of the payload being built

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    osd_run_length_char_buffer_unit #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_op              (op),
        .i_payload_byte    (payload_byte),
        .i_last_of_payload (last_flag),
        .i_read_row        (read_row),
        .i_read_col        (read_col),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_char_code       (char_code)
    );

    osd_run_length_char_buffer_checker #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_op              (op),
        .i_payload_byte    (payload_byte),
        .i_last_of_payload (last_flag),
        .i_read_row        (read_row),
        .i_read_col        (read_col),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_char_code       (char_code),
        .o_fail_count      (fail_count),
        .o_pending         (pending_reads)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // One request on the input channel. Random sender gaps come first; valid
    // then stays high with a fixed payload until the block takes it. When no
    // gap is drawn, valid stays high straight into the next request.
    task automatic send_req(input logic [OP_W-1:0] req_op, input logic [BYTE_W-1:0] b,
                            input logic last, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= req_op;
        payload_byte <= b;
        last_flag    <= last;
        read_row     <= row;
        read_col     <= col;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (req_op != osdrl_pkg::OP_NONE) begin
            req_count++;
        end
    endtask

    // Fields a request does not use are filled at random.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        send_req(osdrl_pkg::OP_BYTE, b, last, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic send_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        send_req(osdrl_pkg::OP_READ, BYTE_W'($urandom), 1'($urandom), row, col);
    endtask

    // Payloads always start at row 0, so most reads look at the top rows.
    task automatic send_random_read();
        logic [ROW_W-1:0] row;
        row = ($urandom_range(9) < 6) ? ROW_W'($urandom_range(2)) : ROW_W'($urandom);
        send_read(row, COL_W'($urandom));
    endtask

    // Append one well-formed token: literal, bank-switched literal or run.
    task automatic add_token();
        int pick;
        logic [RUN_W-1:0] len;
        pick = $urandom_range(99);
        if (pick < 50) begin
            stream.push_back(BYTE_W'($urandom_range(1, 254)));
        end else if (pick < 65) begin
            stream.push_back(osdrl_pkg::BYTE_BANK);
            stream.push_back(BYTE_W'($urandom));
        end else begin
            // mostly short runs; a long one now and then
            len = ($urandom_range(9) == 0) ? RUN_W'($urandom_range(1, 127))
                                           : RUN_W'($urandom_range(1, 8));
            stream.push_back(osdrl_pkg::BYTE_ESC);
            stream.push_back({1'($urandom), len});
            stream.push_back(BYTE_W'($urandom));
        end
    endtask

    // Send the built payload with the last flag on its final byte, with
    // reads slipped in between bytes now and then.
    task automatic send_stream();
        for (int i = 0; i < stream.size(); i++) begin
            if ($urandom_range(9) == 0) begin
                send_random_read();
            end
            send_byte(stream[i], (i == stream.size() - 1));
        end
        stream.delete();
    endtask

    task automatic build_payload();
        int shape;
        int n_tok;
        shape = $urandom_range(99);
        if (shape < 3) begin
            // enough full runs to wrap past the bottom row back to row 0
            for (int i = 0; i < (ROWS*COLS) / 127 + 2; i++) begin
                stream.push_back(osdrl_pkg::BYTE_ESC);
                stream.push_back({1'($urandom), 7'h7f});
                stream.push_back(BYTE_W'($urandom));
            end
        end else begin
            n_tok = $urandom_range(1, 12);
            repeat (n_tok) add_token();
            if (shape < 18) begin
                // zero count, then trailing bytes the block must skip
                stream.push_back(osdrl_pkg::BYTE_ESC);
                stream.push_back(osdrl_pkg::BYTE_ESC);
                repeat ($urandom_range(2)) stream.push_back(BYTE_W'($urandom));
            end else if (shape < 28) begin
                // escape or bank prefix cut off by the last byte
                stream.push_back(($urandom_range(1) == 0) ? osdrl_pkg::BYTE_ESC
                                                          : osdrl_pkg::BYTE_BANK);
            end
        end
    endtask

    initial begin
        int kind;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Store is zero after reset.
        send_read(5'd0, 6'd0);
        send_read(ROW_W'(ROWS - 1), COL_W'(COLS - 1));
        send_byte(8'h01, 1'b0);             // lowest plain literal
        send_byte(8'hfe, 1'b0);             // highest plain literal
        send_byte(osdrl_pkg::BYTE_BANK, 1'b0);  // bank 1, literal 0 follows
        send_byte(8'h00, 1'b0);
        send_byte(osdrl_pkg::BYTE_BANK, 1'b0);  // back to bank 0, literal 255
        send_byte(8'hff, 1'b0);
        send_byte(osdrl_pkg::BYTE_ESC, 1'b0);   // run of 3 with bank toggle
        send_byte(8'h83, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(osdrl_pkg::BYTE_ESC, 1'b0);   // longest run, wraps two rows
        send_byte(8'h7f, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(osdrl_pkg::BYTE_ESC, 1'b0);   // zero count ends the payload
        send_byte(osdrl_pkg::BYTE_ESC, 1'b0);
        send_byte(8'h42, 1'b1);             // skipped, but still restarts
        send_read(5'd0, 6'd0);
        send_read(5'd0, 6'd3);
        send_read(5'd0, 6'd6);
        send_read(5'd2, 6'd5);
        send_byte(osdrl_pkg::BYTE_ESC, 1'b1);   // escape cut off at the end
        send_byte(osdrl_pkg::BYTE_BANK, 1'b1);  // bank prefix cut off at the end
        send_req(osdrl_pkg::OP_NONE, 8'h11, 1'b1, 5'd0, 6'd0);   // unused op, flag ignored
        send_byte(8'h10, 1'b0);             // lands at row 0, column 0, bank 0
        send_req(osdrl_pkg::OP_READ, 8'h00, 1'b1, 5'd0, 6'd0);   // flag on a read
        send_req(osdrl_pkg::OP_CLEAR, 8'h00, 1'b1, 5'd0, 6'd0);  // flag on a clear
        send_read(5'd0, 6'd6);
        send_byte(8'h20, 1'b1);             // decoder kept its place across clear
        send_read(5'd0, 6'd1);

        // Random part: idle profile changes by thirds of the run.
        req_count = 0;
        while (req_count < N_RANDOM) begin
            if (req_count < N_RANDOM / 3) begin
                send_idle_pct = 37;
                recv_idle_pct = 72;
            end else if (req_count < 2 * N_RANDOM / 3) begin
                send_idle_pct = 72;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            kind = $urandom_range(99);
            if (kind < 65) begin
                build_payload();
                send_stream();
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 4)) send_random_read();
            end else if (kind < 93) begin
                // noise: arbitrary bytes, last flag on the final one
                repeat ($urandom_range(1, 6)) stream.push_back(BYTE_W'($urandom));
                send_stream();
            end else if (kind < 98) begin
                send_req(osdrl_pkg::OP_NONE, BYTE_W'($urandom), 1'($urandom),
                         ROW_W'($urandom), COL_W'($urandom));
            end else begin
                send_req(osdrl_pkg::OP_CLEAR, BYTE_W'($urandom), 1'($urandom),
                         ROW_W'($urandom), COL_W'($urandom));
            end
        end
        in_valid <= 1'b0;

        // Let the checker see the final accept, then drain outstanding reads.
        @(posedge clk);
        while (pending_reads != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- osd_run_length_char_buffer_unit.f -----
hw/rtl/osdrl_pkg.sv
hw/rtl/osdrl_ram.sv
hw/rtl/osd_run_length_char_buffer_unit.sv
hw/rtl/osdrl_chk.sv
dv/osd_run_length_char_buffer_checker.sv
dv/tb.sv
